FILE: hdl/sorted_unique_set_list_core_defines.svh
// Assertion macros shared by the sorted set list RTL.
`ifndef SORTED_UNIQUE_SET_LIST_CORE_DEFINES_SVH
`define SORTED_UNIQUE_SET_LIST_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SUS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted set list: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SUS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted set list: assertion failed");

`endif

FILE: hdl/sus_pkg.sv
package sus_pkg;

  localparam int CAPACITY_DEFAULT = 32;
  localparam int VALUE_W = 32;
  localparam int OP_W = 2;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_INSERT    = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE    = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST_ASC  = 2'd2;
  localparam logic [OP_W-1:0] OP_LIST_DESC = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd6;

  // Broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic accept;      // transaction taken: latch compare flags, seed token
    logic start_asc;   // seed read token at the head
    logic start_desc;  // seed read token at the tail
    logic step;        // advance read token one cell
    logic dir_asc;     // token moves toward the tail
    logic insert;      // open a gap and write the operand
    logic remove;      // close the gap over the matching entry
  } cell_ctrl_t;

endpackage

FILE: hdl/sus_cell.sv
module sus_cell import sus_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT,
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cell_ctrl_t                ctrl,
  input  logic [$clog2(CAPACITY+1)-1:0] count,
  input  logic signed [VALUE_W-1:0] key,
  input  logic signed [VALUE_W-1:0] operand,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic signed [VALUE_W-1:0] right_value,
  input  logic                      left_lt,
  input  logic                      left_token,
  input  logic                      right_token,
  output logic signed [VALUE_W-1:0] cell_value,
  output logic                      lt,
  output logic                      eq,
  output logic                      token,
  output logic                      tail_hit,
  output logic signed [VALUE_W-1:0] read_value
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic occupied;
  logic tail_pos;

  assign occupied = CW'(IDX) < count;
  assign tail_pos = CW'(IDX + 1) == count;

  // Compare flags against the incoming key, latched with the transaction.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      lt <= occupied && (cell_value < key);
      eq <= occupied && (cell_value == key);
    end
  end

  // Entries at or above the insert point shift toward the tail; on delete
  // they pull from the tail side.
  always_ff @(posedge clk) begin
    if (ctrl.insert && !lt) begin
      cell_value <= left_lt ? operand : left_value;
    end else if (ctrl.remove && !lt) begin
      cell_value <= right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token <= 1'b0;
    end else if (ctrl.accept) begin
      token <= (ctrl.start_asc && (IDX == 0)) || (ctrl.start_desc && tail_pos);
    end else if (ctrl.step) begin
      token <= ctrl.dir_asc ? left_token : right_token;
    end
  end

  assign tail_hit   = token && (ctrl.dir_asc ? tail_pos : (IDX == 0));
  assign read_value = token ? cell_value : '0;

endmodule

FILE: hdl/sorted_unique_set_list_core.sv
// Insert and delete: every cell latches its compare flags when the transaction
// is taken; the result is loaded into the output register from the execute state
// once that register is free, and no new item is taken until then.
// List: the read token is seeded on acceptance and walks the chain, one element
// per cycle while the output register is free; an empty set gives ST_EMPTY.
// Reset clears the entry count, the sequencer, read tokens and out_valid.
`include "sorted_unique_set_list_core_defines.svh"

module sorted_unique_set_list_core import sus_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            operation,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        status,
  output logic signed [VALUE_W-1:0]  result_value,
  output logic                       last
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                      state;
  logic                      state_next;
  logic [OP_W-1:0]           op_q;
  logic signed [VALUE_W-1:0] operand;
  logic [CW-1:0]             count;

  logic                      accept;
  logic                      out_free;
  logic                      exec_emit;
  logic                      eq_any;
  logic                      full;
  logic                      is_list;
  logic                      list_last;
  logic signed [VALUE_W-1:0] list_value;
  cell_ctrl_t                ctrl;

  logic [STATUS_W-1:0]       res_status;
  logic signed [VALUE_W-1:0] res_value;
  logic                      res_last;
  logic                      done;

  logic signed [VALUE_W-1:0] cell_value [CAPACITY];
  logic signed [VALUE_W-1:0] read_value [CAPACITY];
  logic [CAPACITY-1:0]       cell_lt;
  logic [CAPACITY-1:0]       cell_eq;
  logic [CAPACITY-1:0]       cell_token;
  logic [CAPACITY-1:0]       cell_tail;

  // Take a new transaction only between items; the output register still
  // decouples a pending result from the next acceptance.
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign exec_emit = (state == ST_EXEC) && out_free;

  assign eq_any    = |cell_eq;
  assign list_last = |cell_tail;
  assign full      = (count == CW'(CAPACITY));
  assign is_list   = (op_q == OP_LIST_ASC) || (op_q == OP_LIST_DESC);

  // Gather the element under the read token (at most one cell holds it).
  always_comb begin
    list_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      list_value = list_value | read_value[i];
    end
  end

  always_comb begin
    ctrl.accept     = accept;
    ctrl.start_asc  = accept && (operation == OP_LIST_ASC);
    ctrl.start_desc = accept && (operation == OP_LIST_DESC);
    ctrl.dir_asc    = (op_q == OP_LIST_ASC);
    ctrl.step       = exec_emit && is_list && (count != '0);
    ctrl.insert     = exec_emit && (op_q == OP_INSERT) && !eq_any && !full;
    ctrl.remove     = exec_emit && (op_q == OP_DELETE) && eq_any;
  end

  // The chain: each cell holds one entry, its compare flags and a token bit.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_value;
    logic signed [VALUE_W-1:0] right_value;
    logic                      left_lt;
    logic                      left_token;
    logic                      right_token;

    if (i == 0) begin : g_head
      assign left_value = operand;
      assign left_lt    = 1'b1;
      assign left_token = 1'b0;
    end else begin : g_mid_left
      assign left_value = cell_value[i-1];
      assign left_lt    = cell_lt[i-1];
      assign left_token = cell_token[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[i];
      assign right_token = 1'b0;
    end else begin : g_mid_right
      assign right_value = cell_value[i+1];
      assign right_token = cell_token[i+1];
    end

    sus_cell #(
      .CAPACITY(CAPACITY),
      .IDX(i)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .ctrl(ctrl),
      .count(count),
      .key(value),
      .operand(operand),
      .left_value(left_value),
      .right_value(right_value),
      .left_lt(left_lt),
      .left_token(left_token),
      .right_token(right_token),
      .cell_value(cell_value[i]),
      .lt(cell_lt[i]),
      .eq(cell_eq[i]),
      .token(cell_token[i]),
      .tail_hit(cell_tail[i]),
      .read_value(read_value[i])
    );
  end

  // Build the result for the current step of the item.
  always_comb begin
    res_status = ST_EMPTY;
    res_value  = '0;
    res_last   = 1'b1;
    done       = 1'b1;
    unique case (op_q)
      OP_INSERT: begin
        res_value = operand;
        if (eq_any) begin
          res_status = ST_DUPLICATE;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_INSERTED;
        end
      end
      OP_DELETE: begin
        res_value  = operand;
        res_status = eq_any ? ST_DELETED : ST_ABSENT;
      end
      OP_LIST_ASC, OP_LIST_DESC: begin
        if (count != '0) begin
          res_status = ST_LISTED;
          res_value  = list_value;
          res_last   = list_last;
          done       = list_last;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_emit && done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the operation and operand for the whole item.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= operation;
      operand <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.insert) begin
      count <= count + CW'(1);
    end else if (ctrl.remove) begin
      count <= count - CW'(1);
    end
  end

  // Output register: load on each emitted result, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_emit) begin
      status       <= res_status;
      result_value <= res_value;
      last         <= res_last;
    end
  end

  `SUS_ASSERT_IMPL(a_count_bound, 1'b1, count <= CW'(CAPACITY))
  `SUS_ASSERT_IMPL(a_token_onehot0, 1'b1, $onehot0(cell_token))
  `SUS_ASSERT_IMPL(a_list_token, (state == ST_EXEC) && is_list && (count != '0), $onehot(cell_token))
  `SUS_ASSERT_NEXT(a_insert_grows, ctrl.insert, count == $past(count) + CW'(1))
  `SUS_ASSERT_IMPL(a_no_accept_busy, state == ST_EXEC, !in_ready)

endmodule
